FILE: src/vtpsg_pkg.sv
// shared types and constants for the adapter timer and sound bus block
package vtpsg_pkg;

   localparam int NUM_UNITS_DEFAULT = 2;
   localparam int PSG_REG_COUNT = 16;
   localparam int PSG_IDX_W = $clog2(PSG_REG_COUNT);
   localparam int CNT_W = 18;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   localparam logic [3:0] REG_ORB    = 4'h0;
   localparam logic [3:0] REG_ORA    = 4'h1;
   localparam logic [3:0] REG_DDRB   = 4'h2;
   localparam logic [3:0] REG_DDRA   = 4'h3;
   localparam logic [3:0] REG_T1CL   = 4'h4;
   localparam logic [3:0] REG_T1CH   = 4'h5;
   localparam logic [3:0] REG_T1LL   = 4'h6;
   localparam logic [3:0] REG_T1LH   = 4'h7;
   localparam logic [3:0] REG_T2CL   = 4'h8;
   localparam logic [3:0] REG_T2CH   = 4'h9;
   localparam logic [3:0] REG_SR     = 4'ha;
   localparam logic [3:0] REG_ACR    = 4'hb;
   localparam logic [3:0] REG_PCR    = 4'hc;
   localparam logic [3:0] REG_IFR    = 4'hd;
   localparam logic [3:0] REG_IER    = 4'he;
   localparam logic [3:0] REG_ORA_NH = 4'hf;

   localparam int FLAG_T1_BIT = 6;
   localparam int FLAG_T2_BIT = 5;
   localparam int IRQ_BIT = 7;
   localparam int ACR_T1_FREE_BIT = 6;
   localparam int ACR_T2_PULSE_BIT = 5;
   localparam int FIRED_BIT = 17;

   localparam logic [CNT_W-1:0] CNT_WRAP = 18'h2ffff;

   localparam logic [2:0] BUS_LATCH = 3'd7;
   localparam logic [2:0] BUS_WRITE = 3'd6;
   localparam logic [2:0] BUS_READ  = 3'd5;
   localparam int BUS_RESET_N_BIT = 2;

endpackage

FILE: src/via_timers_psg_register_port_top.sv
// two interface adapters with timers driving sound chip register buses
//
//  channel | ports                                  | moves
//  --------+----------------------------------------+---------------------------
//  req     | req_valid req_stall req_*              | one command word in
//  rsp     | rsp_valid rsp_stall rsp_*              | one result word out
//
//  one word per cycle sustained while rsp_stall is low; a request reaches rsp
//  through the input register, then the state update and result register
//  synchronous reset clears all adapter state and sound registers at once
//  rsp_stall holds the result register and, through req_stall, the input register
module via_timers_psg_register_port_top #(
   parameter int NUM_UNITS = vtpsg_pkg::NUM_UNITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic       req_unit_select,
   input  logic [3:0] req_reg_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic       rsp_irq_line,
   output logic       rsp_psg_write,
   output logic       rsp_psg_unit,
   output logic [3:0] rsp_psg_index,
   output logic [7:0] rsp_psg_value,
   output logic       rsp_psg_reset
);

   localparam int CW = vtpsg_pkg::CNT_W;
   localparam int PN = vtpsg_pkg::PSG_REG_COUNT;
   localparam int PW = vtpsg_pkg::PSG_IDX_W;

   // input register
   logic       in_valid_ff;
   logic [1:0] cmd_ff;
   logic       sel_ff;
   logic [3:0] idx_ff;
   logic [7:0] data_ff;

   // result register
   logic          rsp_valid_ff;
   logic [7:0]    rd_ff, rd_in;
   logic          irq_ff, irq_in;
   logic          pw_ff, pw_in;
   logic          pu_ff, pu_in;
   logic [PW-1:0] pi_ff, pi_in;
   logic [7:0]    pv_ff, pv_in;
   logic          pr_ff, pr_in;

   // adapter state
   logic [7:0]    pb_ff   [NUM_UNITS];
   logic [7:0]    pb_in   [NUM_UNITS];
   logic [7:0]    pa_ff   [NUM_UNITS];
   logic [7:0]    pa_in   [NUM_UNITS];
   logic [7:0]    ddrb_ff [NUM_UNITS];
   logic [7:0]    ddrb_in [NUM_UNITS];
   logic [7:0]    ddra_ff [NUM_UNITS];
   logic [7:0]    ddra_in [NUM_UNITS];
   logic [CW-1:0] t1c_ff  [NUM_UNITS];
   logic [CW-1:0] t1c_in  [NUM_UNITS];
   logic [15:0]   t1l_ff  [NUM_UNITS];
   logic [15:0]   t1l_in  [NUM_UNITS];
   logic [CW-1:0] t2c_ff  [NUM_UNITS];
   logic [CW-1:0] t2c_in  [NUM_UNITS];
   logic [15:0]   t2l_ff  [NUM_UNITS];
   logic [15:0]   t2l_in  [NUM_UNITS];
   logic [7:0]    ifr_ff  [NUM_UNITS];
   logic [7:0]    ifr_in  [NUM_UNITS];
   logic [6:0]    ier_ff  [NUM_UNITS];
   logic [6:0]    ier_in  [NUM_UNITS];
   logic [7:0]    acr_ff  [NUM_UNITS];
   logic [7:0]    acr_in  [NUM_UNITS];
   logic [7:0]    pcr_ff  [NUM_UNITS];
   logic [7:0]    pcr_in  [NUM_UNITS];
   logic [7:0]    sr_ff   [NUM_UNITS];
   logic [7:0]    sr_in   [NUM_UNITS];
   logic [7:0]    lat_ff  [NUM_UNITS];
   logic [7:0]    lat_in  [NUM_UNITS];
   logic [7:0]    psg_ff  [NUM_UNITS][PN];
   logic [7:0]    psg_in  [NUM_UNITS][PN];

   logic out_adv;
   logic proc;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !out_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         cmd_ff  <= req_command;
         sel_ff  <= req_unit_select;
         idx_ff  <= req_reg_index;
         data_ff <= req_write_data;
      end
   end

   always_comb begin
      logic [CW-1:0] c;
      logic [CW-1:0] cm1;
      logic [7:0]    f;
      logic [7:0]    nv;
      logic [7:0]    a;
      logic [7:0]    ra;
      logic [7:0]    rv;
      logic [2:0]    pvb;
      logic          hit;

      c   = '0;
      cm1 = '0;
      f   = '0;
      nv  = '0;
      a   = '0;
      ra  = '0;
      rv  = '0;
      pvb = '0;
      hit = 1'b0;

      rd_in  = '0;
      irq_in = 1'b0;
      pw_in  = 1'b0;
      pu_in  = 1'b0;
      pi_in  = '0;
      pv_in  = '0;
      pr_in  = 1'b0;

      for (int u = 0; u < NUM_UNITS; u++) begin
         pb_in[u]   = pb_ff[u];
         pa_in[u]   = pa_ff[u];
         ddrb_in[u] = ddrb_ff[u];
         ddra_in[u] = ddra_ff[u];
         t1c_in[u]  = t1c_ff[u];
         t1l_in[u]  = t1l_ff[u];
         t2c_in[u]  = t2c_ff[u];
         t2l_in[u]  = t2l_ff[u];
         ier_in[u]  = ier_ff[u];
         acr_in[u]  = acr_ff[u];
         pcr_in[u]  = pcr_ff[u];
         sr_in[u]   = sr_ff[u];
         lat_in[u]  = lat_ff[u];
         psg_in[u]  = psg_ff[u];
         f          = ifr_ff[u];
         hit        = proc && (int'(sel_ff) == u);

         if (proc && cmd_ff == vtpsg_pkg::CMD_TICK) begin
            // timer 1
            c = t1c_ff[u];
            if (c[CW-2:0] != '0) begin
               c = c - CW'(1);
            end else if (acr_ff[u][vtpsg_pkg::ACR_T1_FREE_BIT]) begin
               f[vtpsg_pkg::FLAG_T1_BIT] = 1'b1;
               c = (t1l_ff[u] == 16'h0) ? CW'(1) : CW'(t1l_ff[u]);
            end else begin
               if (!c[vtpsg_pkg::FIRED_BIT]) begin
                  f[vtpsg_pkg::FLAG_T1_BIT] = 1'b1;
               end
               c = vtpsg_pkg::CNT_WRAP;
            end
            t1c_in[u] = c;
            // timer 2
            c = t2c_ff[u];
            if (!acr_ff[u][vtpsg_pkg::ACR_T2_PULSE_BIT]) begin
               if (c[CW-2:0] != '0) begin
                  c = c - CW'(1);
               end else begin
                  if (!c[vtpsg_pkg::FIRED_BIT]) begin
                     f[vtpsg_pkg::FLAG_T2_BIT] = 1'b1;
                  end
                  c = vtpsg_pkg::CNT_WRAP;
               end
            end
            t2c_in[u] = c;
         end else if (hit && cmd_ff == vtpsg_pkg::CMD_READ) begin
            case (idx_ff)
               vtpsg_pkg::REG_ORB: rd_in = pb_ff[u];
               vtpsg_pkg::REG_ORA, vtpsg_pkg::REG_ORA_NH: rd_in = pa_ff[u];
               vtpsg_pkg::REG_DDRB: rd_in = ddrb_ff[u];
               vtpsg_pkg::REG_DDRA: rd_in = ddra_ff[u];
               vtpsg_pkg::REG_T1CL: begin
                  cm1 = t1c_ff[u] - CW'(1);
                  rd_in = cm1[7:0];
                  f[vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
               end
               vtpsg_pkg::REG_T1CH: begin
                  cm1 = t1c_ff[u] - CW'(1);
                  rd_in = cm1[15:8];
               end
               vtpsg_pkg::REG_T1LL: rd_in = t1l_ff[u][7:0];
               vtpsg_pkg::REG_T1LH: rd_in = t1l_ff[u][15:8];
               vtpsg_pkg::REG_T2CL: begin
                  cm1 = t2c_ff[u] - CW'(1);
                  rd_in = cm1[7:0];
                  f[vtpsg_pkg::FLAG_T2_BIT] = 1'b0;
               end
               vtpsg_pkg::REG_T2CH: begin
                  cm1 = t2c_ff[u] - CW'(1);
                  rd_in = cm1[15:8];
               end
               vtpsg_pkg::REG_SR:  rd_in = sr_ff[u];
               vtpsg_pkg::REG_ACR: rd_in = acr_ff[u];
               vtpsg_pkg::REG_PCR: rd_in = pcr_ff[u];
               vtpsg_pkg::REG_IFR: rd_in = ifr_ff[u];
               default:            rd_in = {1'b0, ier_ff[u]};
            endcase
         end else if (hit && cmd_ff == vtpsg_pkg::CMD_WRITE) begin
            case (idx_ff)
               vtpsg_pkg::REG_ORB: begin
                  nv = (data_ff & ddrb_ff[u]) | (pb_ff[u] & ~ddrb_ff[u]);
                  if (nv != pb_ff[u]) begin
                     if (!nv[vtpsg_pkg::BUS_RESET_N_BIT]) begin
                        // sound chip reset
                        for (int k = 0; k < PN; k++) begin
                           psg_in[u][k] = 8'h00;
                        end
                        lat_in[u] = 8'h00;
                        pr_in     = 1'b1;
                        pu_in     = sel_ff;
                     end else begin
                        pvb = pb_ff[u][2:0];
                        a   = lat_ff[u];
                        if (pvb == vtpsg_pkg::BUS_LATCH) begin
                           lat_in[u] = pa_ff[u];
                        end else if (pvb == vtpsg_pkg::BUS_WRITE && a[7:PW] == '0) begin
                           psg_in[u][a[PW-1:0]] = pa_ff[u];
                           pw_in = 1'b1;
                           pu_in = sel_ff;
                           pi_in = a[PW-1:0];
                           pv_in = pa_ff[u];
                        end
                        if (nv[2:0] == vtpsg_pkg::BUS_READ) begin
                           ra = lat_in[u];
                           rv = (ra[7:PW] == '0) ? psg_in[u][ra[PW-1:0]] : 8'h00;
                           pa_in[u] = (pa_ff[u] & ddra_ff[u]) | (rv & ~ddra_ff[u]);
                        end
                     end
                  end
                  pb_in[u] = nv;
               end
               vtpsg_pkg::REG_ORA, vtpsg_pkg::REG_ORA_NH: begin
                  pa_in[u] = (data_ff & ddra_ff[u]) | (pa_ff[u] & ~ddra_ff[u]);
               end
               vtpsg_pkg::REG_DDRB: ddrb_in[u] = data_ff;
               vtpsg_pkg::REG_DDRA: ddra_in[u] = data_ff;
               vtpsg_pkg::REG_T1CL, vtpsg_pkg::REG_T1LL: t1l_in[u][7:0] = data_ff;
               vtpsg_pkg::REG_T1CH: begin
                  t1l_in[u][15:8] = data_ff;
                  t1c_in[u] = CW'({data_ff, t1l_ff[u][7:0]}) + CW'(1);
                  f[vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
               end
               vtpsg_pkg::REG_T1LH: begin
                  t1l_in[u][15:8] = data_ff;
                  f[vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
               end
               vtpsg_pkg::REG_T2CL: t2l_in[u][7:0] = data_ff;
               vtpsg_pkg::REG_T2CH: begin
                  t2l_in[u][15:8] = data_ff;
                  t2c_in[u] = CW'({data_ff, t2l_ff[u][7:0]}) + CW'(1);
                  f[vtpsg_pkg::FLAG_T2_BIT] = 1'b0;
               end
               vtpsg_pkg::REG_SR:  sr_in[u]  = data_ff;
               vtpsg_pkg::REG_ACR: acr_in[u] = data_ff;
               vtpsg_pkg::REG_PCR: pcr_in[u] = data_ff;
               vtpsg_pkg::REG_IFR: f = f & ~data_ff;
               default: begin
                  if (data_ff[7]) begin
                     ier_in[u] = ier_ff[u] | data_ff[6:0];
                  end else begin
                     ier_in[u] = ier_ff[u] & ~data_ff[6:0];
                  end
               end
            endcase
         end

         // summary bit follows the enabled flags
         f[vtpsg_pkg::IRQ_BIT] = |(f[6:0] & ier_in[u]);
         ifr_in[u] = f;
         irq_in = irq_in | f[vtpsg_pkg::IRQ_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int u = 0; u < NUM_UNITS; u++) begin
            pb_ff[u]   <= '0;
            pa_ff[u]   <= '0;
            ddrb_ff[u] <= '0;
            ddra_ff[u] <= '0;
            t1c_ff[u]  <= '0;
            t1l_ff[u]  <= '0;
            t2c_ff[u]  <= '0;
            t2l_ff[u]  <= '0;
            ifr_ff[u]  <= '0;
            ier_ff[u]  <= '0;
            acr_ff[u]  <= '0;
            pcr_ff[u]  <= '0;
            sr_ff[u]   <= '0;
            lat_ff[u]  <= '0;
            for (int k = 0; k < PN; k++) begin
               psg_ff[u][k] <= '0;
            end
         end
      end else if (proc) begin
         for (int u = 0; u < NUM_UNITS; u++) begin
            pb_ff[u]   <= pb_in[u];
            pa_ff[u]   <= pa_in[u];
            ddrb_ff[u] <= ddrb_in[u];
            ddra_ff[u] <= ddra_in[u];
            t1c_ff[u]  <= t1c_in[u];
            t1l_ff[u]  <= t1l_in[u];
            t2c_ff[u]  <= t2c_in[u];
            t2l_ff[u]  <= t2l_in[u];
            ifr_ff[u]  <= ifr_in[u];
            ier_ff[u]  <= ier_in[u];
            acr_ff[u]  <= acr_in[u];
            pcr_ff[u]  <= pcr_in[u];
            sr_ff[u]   <= sr_in[u];
            lat_ff[u]  <= lat_in[u];
            for (int k = 0; k < PN; k++) begin
               psg_ff[u][k] <= psg_in[u][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rd_ff  <= rd_in;
         irq_ff <= irq_in;
         pw_ff  <= pw_in;
         pu_ff  <= pu_in;
         pi_ff  <= pi_in;
         pv_ff  <= pv_in;
         pr_ff  <= pr_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rd_ff;
   assign rsp_irq_line  = irq_ff;
   assign rsp_psg_write = pw_ff;
   assign rsp_psg_unit  = pu_ff;
   assign rsp_psg_index = pi_ff;
   assign rsp_psg_value = pv_ff;
   assign rsp_psg_reset = pr_ff;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the two-unit adapter timer and sound bus block
module testbench;

   localparam int NU = vtpsg_pkg::NUM_UNITS_DEFAULT;
   localparam int CW = vtpsg_pkg::CNT_W;
   localparam int PN = vtpsg_pkg::PSG_REG_COUNT;
   localparam int PW = vtpsg_pkg::PSG_IDX_W;
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [7:0] BUS_IDLE = 8'h04;
   localparam int IDLE_PCT = 17;
   localparam int CALM_FIRST = 500;
   localparam int CALM_LAST = 750;
   localparam int HOLD_AT = 900;
   localparam int HOLD_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORD_TARGET = 1350;
   localparam int TAIL_CYCLES = 8;

   typedef struct packed {
      logic [1:0] command;
      logic       unit_select;
      logic [3:0] reg_index;
      logic [7:0] write_data;
   } bus_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       psg_write;
      logic       psg_unit;
      logic [3:0] psg_index;
      logic [7:0] psg_value;
      logic       psg_reset;
   } bus_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = '0;
   logic       req_unit_select = 1'b0;
   logic [3:0] req_reg_index = '0;
   logic [7:0] req_write_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_irq_line;
   logic       rsp_psg_write;
   logic       rsp_psg_unit;
   logic [3:0] rsp_psg_index;
   logic [7:0] rsp_psg_value;
   logic       rsp_psg_reset;

   bus_word_type   bus_words[$];
   bus_result_type awaited_results[$];
   int word_total = 0;
   int planned_words = 0;
   int issued_count = 0;
   int accepted_count = 0;
   int taken_count = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   // adapter and sound chip state as the block should hold it
   logic [7:0]    pb_out[NU];
   logic [7:0]    pa_out[NU];
   logic [7:0]    pb_dir[NU];
   logic [7:0]    pa_dir[NU];
   logic [CW-1:0] t1_count[NU];
   logic [CW-1:0] t2_count[NU];
   logic [15:0]   t1_latch[NU];
   logic [15:0]   t2_latch[NU];
   logic [7:0]    ifr[NU];
   logic [6:0]    ier[NU];
   logic [7:0]    acr[NU];
   logic [7:0]    pcr[NU];
   logic [7:0]    sr_byte[NU];
   logic [7:0]    snd_addr[NU];
   logic [7:0]    snd_regs[NU][PN];

   via_timers_psg_register_port_top #(.NUM_UNITS(NU)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_unit_select(req_unit_select),
      .req_reg_index(req_reg_index),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_irq_line(rsp_irq_line),
      .rsp_psg_write(rsp_psg_write),
      .rsp_psg_unit(rsp_psg_unit),
      .rsp_psg_index(rsp_psg_index),
      .rsp_psg_value(rsp_psg_value),
      .rsp_psg_reset(rsp_psg_reset)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_adapters();
      int u;
      int i;
      for (u = 0; u < NU; u++) begin
         pb_out[u] = '0;
         pa_out[u] = '0;
         pb_dir[u] = '0;
         pa_dir[u] = '0;
         t1_count[u] = '0;
         t2_count[u] = '0;
         t1_latch[u] = '0;
         t2_latch[u] = '0;
         ifr[u] = '0;
         ier[u] = '0;
         acr[u] = '0;
         pcr[u] = '0;
         sr_byte[u] = '0;
         snd_addr[u] = '0;
         for (i = 0; i < PN; i++) snd_regs[u][i] = '0;
      end
   endfunction

   function automatic void refresh_irq(int u);
      ifr[u][vtpsg_pkg::IRQ_BIT] = |(ifr[u][6:0] & ier[u]);
   endfunction

   function automatic void drive_sound_bus(int u, logic [7:0] nv, logic [7:0] pv,
                                           inout bus_result_type res);
      logic [7:0] a;
      logic [7:0] v;
      int i;
      if (!nv[vtpsg_pkg::BUS_RESET_N_BIT]) begin
         for (i = 0; i < PN; i++) snd_regs[u][i] = '0;
         snd_addr[u] = '0;
         res.psg_reset = 1'b1;
         res.psg_unit = 1'(u);
         return;
      end
      a = snd_addr[u];
      if (pv[2:0] == vtpsg_pkg::BUS_LATCH) begin
         snd_addr[u] = pa_out[u];
      end else if (pv[2:0] == vtpsg_pkg::BUS_WRITE && a < PN) begin
         snd_regs[u][a[PW-1:0]] = pa_out[u];
         res.psg_write = 1'b1;
         res.psg_unit = 1'(u);
         res.psg_index = a[PW-1:0];
         res.psg_value = pa_out[u];
      end
      if (nv[2:0] == vtpsg_pkg::BUS_READ) begin
         a = snd_addr[u];
         v = (a < PN) ? snd_regs[u][a[PW-1:0]] : 8'h00;
         pa_out[u] = (pa_out[u] & pa_dir[u]) | (v & ~pa_dir[u]);
      end
   endfunction

   function automatic void tick_timers(int u);
      logic [CW-1:0] c;
      c = t1_count[u];
      if (c[16:0] != '0) begin
         c = c - CW'(1);
      end else if (acr[u][vtpsg_pkg::ACR_T1_FREE_BIT]) begin
         ifr[u][vtpsg_pkg::FLAG_T1_BIT] = 1'b1;
         c = (t1_latch[u] == '0) ? CW'(1) : CW'(t1_latch[u]);
      end else begin
         if (!c[vtpsg_pkg::FIRED_BIT]) ifr[u][vtpsg_pkg::FLAG_T1_BIT] = 1'b1;
         c = vtpsg_pkg::CNT_WRAP;
      end
      t1_count[u] = c;
      c = t2_count[u];
      if (!acr[u][vtpsg_pkg::ACR_T2_PULSE_BIT]) begin
         if (c[16:0] != '0) begin
            c = c - CW'(1);
         end else begin
            if (!c[vtpsg_pkg::FIRED_BIT]) ifr[u][vtpsg_pkg::FLAG_T2_BIT] = 1'b1;
            c = vtpsg_pkg::CNT_WRAP;
         end
      end
      t2_count[u] = c;
      refresh_irq(u);
   endfunction

   function automatic logic [7:0] read_adapter(int u, logic [3:0] r);
      logic [CW-1:0] m1;
      logic [CW-1:0] m2;
      m1 = t1_count[u] - CW'(1);
      m2 = t2_count[u] - CW'(1);
      case (r)
         vtpsg_pkg::REG_ORB: return pb_out[u];
         vtpsg_pkg::REG_ORA, vtpsg_pkg::REG_ORA_NH: return pa_out[u];
         vtpsg_pkg::REG_DDRB: return pb_dir[u];
         vtpsg_pkg::REG_DDRA: return pa_dir[u];
         vtpsg_pkg::REG_T1CL: begin
            ifr[u][vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
            refresh_irq(u);
            return m1[7:0];
         end
         vtpsg_pkg::REG_T1CH: return m1[15:8];
         vtpsg_pkg::REG_T1LL: return t1_latch[u][7:0];
         vtpsg_pkg::REG_T1LH: return t1_latch[u][15:8];
         vtpsg_pkg::REG_T2CL: begin
            ifr[u][vtpsg_pkg::FLAG_T2_BIT] = 1'b0;
            refresh_irq(u);
            return m2[7:0];
         end
         vtpsg_pkg::REG_T2CH: return m2[15:8];
         vtpsg_pkg::REG_SR: return sr_byte[u];
         vtpsg_pkg::REG_ACR: return acr[u];
         vtpsg_pkg::REG_PCR: return pcr[u];
         vtpsg_pkg::REG_IFR: return ifr[u];
         default: return {1'b0, ier[u]};
      endcase
   endfunction

   function automatic void write_adapter(int u, logic [3:0] r, logic [7:0] v,
                                         inout bus_result_type res);
      logic [7:0] nv;
      case (r)
         vtpsg_pkg::REG_ORB: begin
            nv = (v & pb_dir[u]) | (pb_out[u] & ~pb_dir[u]);
            if (nv != pb_out[u]) drive_sound_bus(u, nv, pb_out[u], res);
            pb_out[u] = nv;
         end
         vtpsg_pkg::REG_ORA, vtpsg_pkg::REG_ORA_NH:
            pa_out[u] = (v & pa_dir[u]) | (pa_out[u] & ~pa_dir[u]);
         vtpsg_pkg::REG_DDRB: pb_dir[u] = v;
         vtpsg_pkg::REG_DDRA: pa_dir[u] = v;
         vtpsg_pkg::REG_T1CL, vtpsg_pkg::REG_T1LL: t1_latch[u][7:0] = v;
         vtpsg_pkg::REG_T1CH: begin
            t1_latch[u][15:8] = v;
            t1_count[u] = CW'(t1_latch[u]) + CW'(1);
            ifr[u][vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
            refresh_irq(u);
         end
         vtpsg_pkg::REG_T1LH: begin
            t1_latch[u][15:8] = v;
            ifr[u][vtpsg_pkg::FLAG_T1_BIT] = 1'b0;
            refresh_irq(u);
         end
         vtpsg_pkg::REG_T2CL: t2_latch[u][7:0] = v;
         vtpsg_pkg::REG_T2CH: begin
            t2_latch[u][15:8] = v;
            t2_count[u] = CW'(t2_latch[u]) + CW'(1);
            ifr[u][vtpsg_pkg::FLAG_T2_BIT] = 1'b0;
            refresh_irq(u);
         end
         vtpsg_pkg::REG_SR: sr_byte[u] = v;
         vtpsg_pkg::REG_ACR: acr[u] = v;
         vtpsg_pkg::REG_PCR: pcr[u] = v;
         vtpsg_pkg::REG_IFR: begin
            ifr[u] = ifr[u] & ~v;
            refresh_irq(u);
         end
         default: begin
            if (v[7]) ier[u] = ier[u] | v[6:0];
            else ier[u] = ier[u] & ~v[6:0];
            refresh_irq(u);
         end
      endcase
   endfunction

   function automatic bus_result_type predict_result(bus_word_type w);
      bus_result_type res;
      int u;
      res = '0;
      if (w.command == vtpsg_pkg::CMD_TICK) begin
         for (u = 0; u < NU; u++) tick_timers(u);
      end else if (w.command == vtpsg_pkg::CMD_READ && int'(w.unit_select) < NU) begin
         res.read_data = read_adapter(int'(w.unit_select), w.reg_index);
      end else if (w.command == vtpsg_pkg::CMD_WRITE && int'(w.unit_select) < NU) begin
         write_adapter(int'(w.unit_select), w.reg_index, w.write_data, res);
      end
      for (u = 0; u < NU; u++) if (ifr[u][vtpsg_pkg::IRQ_BIT]) res.irq_line = 1'b1;
      return res;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         error_count++;
      end
   endfunction

   task automatic push_word(logic [1:0] cmd, int u, logic [3:0] idx, logic [7:0] data);
      bus_word_type w;
      w.command = cmd;
      w.unit_select = 1'(u);
      w.reg_index = idx;
      w.write_data = data;
      bus_words.push_back(w);
      if (cmd != CMD_NONE) word_total++;
   endtask

   task automatic bus_write(int u, logic [3:0] idx, logic [7:0] data);
      push_word(vtpsg_pkg::CMD_WRITE, u, idx, data);
   endtask

   task automatic bus_read(int u, logic [3:0] idx);
      push_word(vtpsg_pkg::CMD_READ, u, idx, 8'($urandom));
   endtask

   task automatic tick_burst(int n);
      int i;
      for (i = 0; i < n; i++) push_word(vtpsg_pkg::CMD_TICK, $urandom_range(0, 1),
                                        4'($urandom), 8'($urandom));
   endtask

   task automatic bus_select(int u, logic [7:0] addr);
      bus_write(u, vtpsg_pkg::REG_DDRB, {5'($urandom), 3'b111});
      bus_write(u, vtpsg_pkg::REG_DDRA, 8'hff);
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), BUS_IDLE[2:0]});
      bus_write(u, vtpsg_pkg::REG_ORA, addr);
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), vtpsg_pkg::BUS_LATCH});
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), BUS_IDLE[2:0]});
   endtask

   task automatic sound_store(int u, logic [7:0] addr, logic [7:0] val);
      bus_select(u, addr);
      bus_write(u, vtpsg_pkg::REG_ORA, val);
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), vtpsg_pkg::BUS_WRITE});
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), BUS_IDLE[2:0]});
   endtask

   task automatic sound_fetch(int u, logic [7:0] addr);
      bus_select(u, addr);
      bus_write(u, vtpsg_pkg::REG_DDRA,
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), vtpsg_pkg::BUS_READ});
      bus_read(u, $urandom_range(0, 1) ? vtpsg_pkg::REG_ORA : vtpsg_pkg::REG_ORA_NH);
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), BUS_IDLE[2:0]});
   endtask

   task automatic sound_clear(int u);
      bus_write(u, vtpsg_pkg::REG_DDRB, {5'($urandom), 3'b111});
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), 1'b0, 2'($urandom)});
      bus_write(u, vtpsg_pkg::REG_ORB, {5'($urandom), BUS_IDLE[2:0]});
   endtask

   task automatic timer_run(int u);
      logic [3:0] peek[6];
      int n;
      int i;
      peek = '{vtpsg_pkg::REG_T1CL, vtpsg_pkg::REG_T1CH, vtpsg_pkg::REG_T2CL,
               vtpsg_pkg::REG_T2CH, vtpsg_pkg::REG_IFR, vtpsg_pkg::REG_IER};
      bus_write(u, vtpsg_pkg::REG_ACR, 8'($urandom));
      bus_write(u, vtpsg_pkg::REG_IER, {1'($urandom), 7'($urandom)});
      bus_write(u, $urandom_range(0, 1) ? vtpsg_pkg::REG_T1CL : vtpsg_pkg::REG_T1LL,
                8'($urandom_range(0, 12)));
      bus_write(u, $urandom_range(0, 1) ? vtpsg_pkg::REG_T1CH : vtpsg_pkg::REG_T1LH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
      bus_write(u, vtpsg_pkg::REG_T2CL, 8'($urandom_range(0, 12)));
      bus_write(u, vtpsg_pkg::REG_T2CH,
                ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
      n = $urandom_range(1, 30);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) bus_read(u, peek[$urandom_range(0, 5)]);
         else tick_burst(1);
      end
      if ($urandom_range(0, 2) == 0) bus_write(u, vtpsg_pkg::REG_IFR, 8'($urandom));
   endtask

   task automatic noise_words();
      int n;
      int i;
      logic [1:0] cmd;
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
         cmd = ($urandom_range(0, 19) == 0) ? CMD_NONE : 2'($urandom_range(0, 2));
         push_word(cmd, $urandom_range(0, 1), 4'($urandom), 8'($urandom));
      end
   endtask

   task automatic build_directed();
      sound_store(0, 8'h0f, 8'hff);
      bus_write(0, vtpsg_pkg::REG_DDRA, 8'h00);
      bus_write(0, vtpsg_pkg::REG_ORB, {5'h00, vtpsg_pkg::BUS_READ});
      bus_read(0, vtpsg_pkg::REG_ORA_NH);
      bus_write(0, vtpsg_pkg::REG_ORB, 8'h00);
      bus_write(1, vtpsg_pkg::REG_T1LL, 8'h00);
      bus_write(1, vtpsg_pkg::REG_T1CH, 8'h00);
      bus_write(1, vtpsg_pkg::REG_IER, 8'hff);
      bus_write(1, vtpsg_pkg::REG_ACR, 8'h40);
      tick_burst(3);
      bus_read(1, vtpsg_pkg::REG_T1CL);
      bus_write(1, vtpsg_pkg::REG_IFR, 8'hff);
      push_word(CMD_NONE, 1, vtpsg_pkg::REG_ORA_NH, 8'hff);
      bus_write(0, vtpsg_pkg::REG_T2CL, 8'hff);
      bus_write(0, vtpsg_pkg::REG_T2CH, 8'hff);
      bus_read(0, vtpsg_pkg::REG_T2CH);
   endtask

   task automatic build_random();
      int pick;
      while (word_total < WORD_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) sound_store($urandom_range(0, 1), 8'($urandom_range(0, 19)),
                                    8'($urandom));
         else if (pick < 40) sound_fetch($urandom_range(0, 1), 8'($urandom_range(0, 19)));
         else if (pick < 45) sound_clear($urandom_range(0, 1));
         else if (pick < 70) timer_run($urandom_range(0, 1));
         else if (pick < 80) tick_burst($urandom_range(1, 10));
         else noise_words();
      end
   endtask

   always @(posedge clock) begin : word_sender
      bus_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (bus_words.size() > 0 && ((issued_count >= CALM_FIRST && issued_count < CALM_LAST)
                                      || $urandom_range(0, 99) >= IDLE_PCT)) begin
            w = bus_words.pop_front();
            req_command <= w.command;
            req_unit_select <= w.unit_select;
            req_reg_index <= w.reg_index;
            req_write_data <= w.write_data;
            req_valid <= 1'b1;
            issued_count <= issued_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         awaited_results.push_back(predict_result(bus_word_type'({req_command,
                                   req_unit_select, req_reg_index, req_write_data})));
         accepted_count++;
      end
   end

   // random stalls, a stall-free window, and one long hold-off so the pipeline backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (taken_count >= HOLD_AT && !holdoff_done) begin
         rsp_stall <= 1'b1;
         holdoff_left <= HOLD_CYCLES;
         holdoff_done <= 1'b1;
      end else if (taken_count >= CALM_FIRST && taken_count < CALM_LAST) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : result_check
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         taken_count <= taken_count + 1;
         if (awaited_results.size() == 0) begin
            $display("%0t: result word with nothing pending", $time);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("read_data", int'(want.read_data), int'(rsp_read_data));
            check_field("irq_line", int'(want.irq_line), int'(rsp_irq_line));
            check_field("psg_write", int'(want.psg_write), int'(rsp_psg_write));
            check_field("psg_unit", int'(want.psg_unit), int'(rsp_psg_unit));
            check_field("psg_index", int'(want.psg_index), int'(rsp_psg_index));
            check_field("psg_value", int'(want.psg_value), int'(rsp_psg_value));
            check_field("psg_reset", int'(want.psg_reset), int'(rsp_psg_reset));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clear_adapters();
      build_directed();
      build_random();
      planned_words = bus_words.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < planned_words || awaited_results.size() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
